### src/cpra_pkg.sv
// Shared types and constants for the contiguous page-run allocator.
`default_nettype none

package cpra_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int WORD_BITS  = 8;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int NUM_WORDS  = NUM_PAGES / WORD_BITS;
    localparam int WIDX_W     = PAGE_W - BIT_W;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 13;
    localparam int PAGE_SHIFT = 12;
    localparam int FIDX_W     = ADDR_W - PAGE_SHIFT;
    localparam int STATUS_W   = 2;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'hC010_0000;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_NOFIT,
        RES_BAD,
        RES_RANGE
    } t_res;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DEC,
        S_FSET,
        S_SCAN,
        S_RINIT,
        S_RD,
        S_WR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic dec;
        logic fset;
        logic scan;
        logic rinit;
        logic rd;
        logic wr;
        logic clr;
        t_res res;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic cnt_zero;
        logic cnt_big;
        logic free_nop;
        logic free_below;
        logic free_out;
        logic found;
        logic scan_end;
        logic range_last;
    } t_dp_sts;

endpackage

`default_nettype wire

### src/contiguous_page_run_allocator.sv
// Top level of the contiguous page-run allocator: config register and result register.
//
// Usage: one request beat in on s_axis, one result beat out on m_axis per request.
// s_axis_tuser carries func (0 allocate, 1 free); s_axis_tdata carries address and
// page_count. m_axis_tdata carries status and result_address.
// Allocate finds the lowest run of page_count free pages (first fit), marks it used
// and answers base_address + start_page * 4096; free clears the run at address.
// base_address is written through i_cfg_wen / i_cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// After reset a clearing pass zeroes all 512 words of the bitmap, one 8-page word
// per cycle; s_axis_tready stays low until it ends. The bitmap is held as 512 words
// of 8 pages. An allocate scans one word per cycle up to the hit, then reads and
// writes back each word the run covers; a failed allocate scans the whole map. A
// free updates its run the same way; a free wholly past the map and rejected or
// empty requests skip the update. One request is in work at a time.
// Results go to an output register; the next request is taken while a result waits.
// If the receiver stalls with a result held, a finished request waits in its
// response state until the register frees up.
`default_nettype none

module contiguous_page_run_allocator
    import cpra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [31:0] address, [44:32] page_count
    input  wire logic [0:0]  s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [1:0] status, [33:2] result_address
    input  wire logic        i_cfg_wen,
    input  wire logic [31:0] i_cfg_wdata
);

    logic [ADDR_W-1:0] r_base;
    logic              r_m_valid;
    logic [39:0]       r_m_data;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    t_status           res_status;
    logic [ADDR_W-1:0] res_addr;
    logic              push;
    logic              out_free;

    assign out_free = !r_m_valid || m_axis_tready;

    cpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready),
        .o_push     (push)
    );

    cpra_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_func     (s_axis_tuser[0]),
        .i_addr     (s_axis_tdata[31:0]),
        .i_cnt      (s_axis_tdata[44:32]),
        .i_base     (r_base),
        .o_sts      (sts),
        .o_status   (res_status),
        .o_res_addr (res_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_wen) begin
            r_base <= i_cfg_wdata;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (push) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_m_data <= {6'd0, res_addr, res_status};
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

### src/cpra_ctrl.sv
// Controller state machine of the page-run allocator.
`default_nettype none

module cpra_ctrl
    import cpra_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_free,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_in_ready,
    output logic         o_push
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (!i_sts.is_free) begin
                    if (i_sts.cnt_zero || i_sts.cnt_big) n_state = S_RESP;
                    else n_state = S_SCAN;
                end else begin
                    if (i_sts.free_nop || i_sts.free_below) n_state = S_RESP;
                    else n_state = S_FSET;
                end
            end
            S_FSET: begin
                if (i_sts.free_out) n_state = S_RESP;
                else n_state = S_RINIT;
            end
            S_SCAN: begin
                if (i_sts.found) n_state = S_RINIT;
                else if (i_sts.scan_end) n_state = S_RESP;
            end
            S_RINIT: n_state = S_RD;
            S_RD:    n_state = S_WR;
            S_WR: begin
                if (i_sts.range_last) n_state = S_RESP;
                else n_state = S_RD;
            end
            S_RESP: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load  = 1'b0;
        o_cmd.dec   = 1'b0;
        o_cmd.fset  = 1'b0;
        o_cmd.scan  = 1'b0;
        o_cmd.rinit = 1'b0;
        o_cmd.rd    = 1'b0;
        o_cmd.wr    = 1'b0;
        o_cmd.clr   = 1'b0;
        o_cmd.res   = RES_NONE;
        o_in_ready  = 1'b0;
        o_push      = 1'b0;
        case (r_state)
            S_CLR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                if (!i_sts.is_free) begin
                    if (i_sts.cnt_zero) o_cmd.res = RES_BAD;
                    else if (i_sts.cnt_big) o_cmd.res = RES_NOFIT;
                end else begin
                    if (i_sts.free_nop) o_cmd.res = RES_OK;
                    else if (i_sts.free_below) o_cmd.res = RES_BAD;
                end
            end
            S_FSET: begin
                o_cmd.fset = 1'b1;
                if (i_sts.free_out) o_cmd.res = RES_OK;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (!i_sts.found && i_sts.scan_end) o_cmd.res = RES_NOFIT;
            end
            S_RINIT: begin
                o_cmd.rinit = 1'b1;
                o_cmd.res   = RES_RANGE;
            end
            S_RD:   o_cmd.rd = 1'b1;
            S_WR:   o_cmd.wr = 1'b1;
            S_RESP: o_push = i_out_free;
            default: o_cmd.res = RES_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DEC))
        else $error("accepted beat not followed by decode");
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLR) |=> (r_state != S_CLR))
        else $error("clearing pass re-entered");
`endif

endmodule

`default_nettype wire

### src/cpra_dp.sv
// Datapath: page bitmap memory, run scanner, range update and result registers.
`default_nettype none

module cpra_dp
    import cpra_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic              i_func,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [CNT_W-1:0]  i_cnt,
    input  wire logic [ADDR_W-1:0] i_base,
    output t_dp_sts                o_sts,
    output t_status                o_status,
    output logic [ADDR_W-1:0]      o_res_addr
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic                 r_func;
    logic [ADDR_W-1:0]    r_addr;
    logic [CNT_W-1:0]     r_cnt;
    logic [FIDX_W-1:0]    r_fidx;
    logic [WIDX_W:0]      r_ra;
    logic [WIDX_W-1:0]    r_sw;
    logic                 r_dv;
    logic [CNT_W-1:0]     r_run;
    logic [PAGE_W-1:0]    r_lo;
    logic [PAGE_W-1:0]    r_hi;
    logic [WIDX_W-1:0]    r_wa;
    logic [WIDX_W-1:0]    r_clr;
    logic [WORD_BITS-1:0] r_rd_data;
    t_status              r_status;
    logic [ADDR_W-1:0]    r_res_addr;

    logic                 issue;
    logic [WIDX_W-1:0]    mem_ra;
    logic [WIDX_W-1:0]    mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mask;
    logic [CNT_W-1:0]     run;
    logic                 hit;
    logic [BIT_W-1:0]     hit_b;
    logic [PAGE_W-1:0]    end_pg;
    logic [ADDR_W-1:0]    start32;
    logic [ADDR_W-1:0]    diff;
    logic [ADDR_W-1:0]    fsum;

    assign issue  = ({1'b0, r_ra} < (WIDX_W+2)'(NUM_WORDS));
    assign mem_ra = i_cmd.scan ? r_ra[WIDX_W-1:0] : r_wa;
    assign mem_wa = i_cmd.clr ? r_clr : r_wa;
    assign mem_we = i_cmd.clr || i_cmd.wr;
    assign mem_wd = i_cmd.clr ? '0 :
                    (r_func == FN_ALLOC) ? (r_rd_data | mask) : (r_rd_data & ~mask);

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (i_cmd.scan || i_cmd.rd) r_rd_data <= mem[mem_ra];
    end

    // bits of the current word that fall inside [lo, hi]
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ({r_wa, BIT_W'(b)} >= r_lo) && ({r_wa, BIT_W'(b)} <= r_hi);
        end
    end

    // extend the free run over one word, stop at the first bit that completes it
    always_comb begin
        run   = r_run;
        hit   = 1'b0;
        hit_b = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (!hit) begin
                if (r_rd_data[b]) run = '0;
                else run = run + 1'b1;
                if (run == r_cnt) begin
                    hit   = 1'b1;
                    hit_b = BIT_W'(b);
                end
            end
        end
    end

    assign end_pg  = {r_sw, hit_b};
    assign start32 = ADDR_W'(end_pg) + 1'b1 - ADDR_W'(r_cnt);
    assign diff    = r_addr - i_base;
    assign fsum    = ADDR_W'(r_fidx) + ADDR_W'(r_cnt) - 1'b1;

    always_comb begin
        o_sts.clr_last   = (r_clr == WIDX_W'(NUM_WORDS - 1));
        o_sts.is_free    = (r_func == FN_FREE);
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.cnt_big    = (ADDR_W'(r_cnt) > ADDR_W'(NUM_PAGES));
        o_sts.free_nop   = (r_cnt == '0) || (r_addr == '0);
        o_sts.free_below = (r_addr < i_base);
        o_sts.free_out   = (ADDR_W'(r_fidx) >= ADDR_W'(NUM_PAGES));
        o_sts.found      = i_cmd.scan && r_dv && hit;
        o_sts.scan_end   = i_cmd.scan && r_dv && !hit &&
                           (r_sw == WIDX_W'(NUM_WORDS - 1));
        o_sts.range_last = (r_wa == r_hi[PAGE_W-1:BIT_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv  <= 1'b0;
            r_clr <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.dec) r_dv <= 1'b0;
            else if (i_cmd.scan) r_dv <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_addr <= i_addr;
            r_cnt  <= i_cnt;
        end
        if (i_cmd.dec) begin
            r_fidx <= diff[ADDR_W-1:PAGE_SHIFT];
            r_ra   <= '0;
            r_run  <= '0;
        end
        if (i_cmd.scan) begin
            r_ra <= r_ra + (WIDX_W+1)'(issue);
            r_sw <= r_ra[WIDX_W-1:0];
            if (r_dv) r_run <= run;
            if (r_dv && hit) begin
                r_lo <= start32[PAGE_W-1:0];
                r_hi <= end_pg;
            end
        end
        if (i_cmd.fset) begin
            r_lo <= r_fidx[PAGE_W-1:0];
            // clip the run at the end of the map
            if (fsum >= ADDR_W'(NUM_PAGES - 1)) r_hi <= PAGE_W'(NUM_PAGES - 1);
            else r_hi <= fsum[PAGE_W-1:0];
        end
        if (i_cmd.rinit) r_wa <= r_lo[PAGE_W-1:BIT_W];
        if (i_cmd.wr) r_wa <= r_wa + 1'b1;
        case (i_cmd.res)
            RES_OK: begin
                r_status   <= ST_DONE;
                r_res_addr <= '0;
            end
            RES_NOFIT: begin
                r_status   <= ST_NOFIT;
                r_res_addr <= '0;
            end
            RES_BAD: begin
                r_status   <= ST_BAD;
                r_res_addr <= '0;
            end
            RES_RANGE: begin
                r_status   <= ST_DONE;
                r_res_addr <= (r_func == FN_ALLOC) ?
                              i_base + (ADDR_W'(r_lo) << PAGE_SHIFT) : '0;
            end
            default: begin
                r_status   <= r_status;
                r_res_addr <= r_res_addr;
            end
        endcase
    end

    assign o_status   = r_status;
    assign o_res_addr = r_res_addr;

`ifndef SYNTHESIS
    a_range_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> (r_wa <= r_hi[PAGE_W-1:BIT_W]))
        else $error("range update ran past its last word");
`endif

endmodule

`default_nettype wire

### tb/page_run_checker.sv
// Checker for the page-run allocator: keeps its own page map and compares every result beat.
`timescale 1ns / 100ps

module page_run_checker
    import cpra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [31:0] address, [44:32] page_count
    input  wire logic [0:0]  s_axis_tuser,   // [0] func
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // [1:0] status, [33:2] result_address
    input  wire logic        i_cfg_wen,
    input  wire logic [31:0] i_cfg_wdata,
    output int               o_mismatches,
    output int               o_owed
);

    typedef struct {
        t_status     status;
        logic [31:0] addr;
    } t_reply;

    logic [NUM_PAGES-1:0] page_used;
    logic [31:0]          base_addr;
    t_reply               owed_replies[$];
    int                   mismatches = 0;
    int                   beat_no = 0;

    // Apply one request to the page map and work out the reply it earns.
    task automatic serve_request(input logic fn, input logic [31:0] addr,
                                 input logic [CNT_W-1:0] pages, output t_reply r);
        logic [31:0] run;
        logic [31:0] first;
        logic [31:0] pg;
        bit          hit;
        r.status = ST_DONE;
        r.addr   = '0;
        hit      = 1'b0;
        run      = '0;
        first    = '0;
        if (fn == FN_ALLOC) begin
            if (pages == 0) begin
                r.status = ST_BAD;
            end else begin
                r.status = ST_NOFIT;
                if (pages <= NUM_PAGES) begin
                    // first fit: lowest run of free pages long enough
                    for (pg = 0; pg < NUM_PAGES && !hit; pg++) begin
                        if (page_used[pg]) begin
                            run = '0;
                        end else begin
                            run++;
                            if (run == pages) begin
                                hit   = 1'b1;
                                first = pg + 1 - pages;
                            end
                        end
                    end
                end
                if (hit) begin
                    for (pg = first; pg < first + pages; pg++)
                        page_used[pg] = 1'b1;
                    r.status = ST_DONE;
                    r.addr   = base_addr + (first << PAGE_SHIFT);
                end
            end
        end else if (pages != 0 && addr != 0) begin
            if (addr < base_addr) begin
                r.status = ST_BAD;
            end else begin
                // drop pages that lie past the end of the map
                first = (addr - base_addr) >> PAGE_SHIFT;
                for (pg = first; pg < first + pages && pg < NUM_PAGES; pg++)
                    page_used[pg] = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            page_used = '0;
            base_addr = BASE_RESET;
            owed_replies.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beat_no++;
                if (owed_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat %0d arrived with nothing outstanding: %h",
                                 beat_no, m_axis_tdata);
                end else begin
                    want = owed_replies.pop_front();
                    if (m_axis_tdata[1:0] !== want.status ||
                        m_axis_tdata[33:2] !== want.addr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: status exp %0d got %0d, address exp %h got %h",
                                     beat_no, want.status, m_axis_tdata[1:0],
                                     want.addr, m_axis_tdata[33:2]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                serve_request(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[44:32], want);
                owed_replies.push_back(want);
            end
            if (i_cfg_wen)
                base_addr = i_cfg_wdata;
        end
        o_mismatches <= mismatches;
        o_owed       <= owed_replies.size();
    end

endmodule

### tb/contiguous_page_run_allocator_tb.sv
// Testbench top for the page-run allocator: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module contiguous_page_run_allocator_tb;
    import cpra_pkg::*;

    localparam int          STALL_LIMIT = 10000;
    localparam int          LONG_HOLD   = 400;
    localparam logic [31:0] PG          = 32'h1000;

    typedef struct {
        logic             fn;
        logic [CNT_W-1:0] pages;
    } t_request;

    typedef struct {
        logic [31:0]      addr;
        logic [CNT_W-1:0] pages;
    } t_page_run;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [31:0] address, [44:32] page_count
    logic [0:0]  s_axis_tuser;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [1:0] status, [33:2] result_address
    logic        i_cfg_wen;
    logic [31:0] i_cfg_wdata;
    int          mismatches;
    int          owed;

    t_request    open_requests[$];
    t_page_run   held_runs[$];
    logic [31:0] cur_base;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    int          granted = 0;
    int          refused = 0;
    int          rejected = 0;
    int          frees = 0;
    int          phases = 0;

    contiguous_page_run_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    page_run_checker i_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_owed        (owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Track granted runs so that later frees can hand them back.
    always @(posedge i_clk) begin : bookkeeping
        t_request  req;
        t_page_run run;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready && open_requests.size() != 0) begin
                req = open_requests.pop_front();
                if (req.fn == FN_FREE) begin
                    frees++;
                end else if (m_axis_tdata[1:0] == ST_DONE) begin
                    granted++;
                    run.addr  = m_axis_tdata[33:2];
                    run.pages = req.pages;
                    held_runs.push_back(run);
                end else if (m_axis_tdata[1:0] == ST_NOFIT) begin
                    refused++;
                end else begin
                    rejected++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.fn    = s_axis_tuser[0];
                req.pages = s_axis_tdata[44:32];
                open_requests.push_back(req);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random ready patterns in spans, plus long hold-offs to back up the block.
    initial begin : sink
        int mode;
        int span;
        int got;
        int next_hold;
        int hold_left;
        mode          = 0;
        span          = 0;
        got           = 0;
        next_hold     = 300;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                got++;
            if (got >= next_hold) begin
                hold_left = LONG_HOLD;
                next_hold += 1000;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
            end
            span--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Present one request and hold it until taken; gaps fall between bursts.
    task automatic offer(input logic fn, input logic [31:0] addr,
                         input logic [CNT_W-1:0] pages);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {3'b000, pages, addr};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if ($urandom_range(0, 9) >= 3) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and wait for every outstanding reply.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (owed != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input bit set_base, input logic [31:0] new_base,
                             input int n_items);
        int               n;
        int               pick;
        int               k;
        logic [31:0]      idx;
        logic [CNT_W-1:0] pages;
        t_page_run        run;
        drain;
        if (set_base) begin
            i_cfg_wen   <= 1'b1;
            i_cfg_wdata <= new_base;
            @(posedge i_clk);
            i_cfg_wen   <= 1'b0;
            cur_base = new_base;
        end
        phases++;
        // start from an empty map; a zero base needs a nonzero address in page zero
        offer(FN_FREE, (cur_base == 0) ? 32'd1 : cur_base, CNT_W'(NUM_PAGES));
        drain;
        held_runs.delete();
        for (n = 0; n < n_items; n++) begin
            if (n == n_items / 2)
                drain;
            pick = $urandom_range(0, 99);
            if (pick < 50 && held_runs.size() > 48)
                pick = 60;
            if (pick >= 50 && pick < 85 && held_runs.size() == 0)
                pick = 88;
            if (pick < 50) begin
                k = $urandom_range(0, 99);
                if (k < 65)
                    pages = CNT_W'($urandom_range(1, 8));
                else if (k < 88)
                    pages = CNT_W'($urandom_range(9, 64));
                else if (k < 97)
                    pages = CNT_W'($urandom_range(65, 512));
                else
                    pages = CNT_W'($urandom_range(513, NUM_PAGES));
                offer(FN_ALLOC, $urandom, pages);
            end else if (pick < 85) begin
                // hand back a granted run, now and then only part of it
                k   = $urandom_range(0, held_runs.size() - 1);
                run = held_runs[k];
                held_runs.delete(k);
                pages = ($urandom_range(0, 9) == 0) ?
                        CNT_W'($urandom_range(1, run.pages)) : run.pages;
                offer(FN_FREE, run.addr + $urandom_range(0, PG - 1), pages);
            end else if (pick < 93) begin
                idx = $urandom_range(0, NUM_PAGES - 1);
                offer(FN_FREE, cur_base + (idx << PAGE_SHIFT) + $urandom_range(0, PG - 1),
                      CNT_W'($urandom_range(1, 64)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       offer(1'($urandom_range(0, 1)), $urandom,
                                   CNT_W'($urandom_range(0, 8191)));
                    1:       offer(FN_FREE, '0, CNT_W'($urandom_range(1, 8191)));
                    2:       offer(1'($urandom_range(0, 1)), $urandom, '0);
                    default: offer(FN_FREE, cur_base - $urandom_range(1, PG),
                                   CNT_W'($urandom_range(1, 64)));
                endcase
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_wen     = 1'b0;
        i_cfg_wdata   = '0;
        cur_base      = BASE_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at the reset base
        offer(FN_ALLOC, '0, 0);                                  // zero count
        offer(FN_ALLOC, 32'h1234_5678, CNT_W'(NUM_PAGES + 1));   // larger than the map
        offer(FN_ALLOC, '1, 13'h1FFF);
        offer(FN_ALLOC, '0, 1);                                  // page zero
        offer(FN_ALLOC, '0, CNT_W'(NUM_PAGES));                  // no room left
        offer(FN_FREE, cur_base, 1);
        offer(FN_ALLOC, '0, CNT_W'(NUM_PAGES));                  // whole map
        offer(FN_ALLOC, '0, 1);                                  // map full
        offer(FN_FREE, '0, 5);                                   // null address
        offer(FN_FREE, cur_base - 1, 1);                         // below base
        offer(FN_FREE, cur_base, 0);                             // zero count
        offer(FN_FREE, cur_base + (NUM_PAGES - 1) * PG + 32'hFFF, 13'h1FFF);  // runs off end
        offer(FN_FREE, cur_base + 10 * PG + 32'h800, 3);         // unaligned address
        offer(FN_ALLOC, '0, 4);                                  // holes too short
        offer(FN_ALLOC, '0, 3);
        offer(FN_ALLOC, '0, 1);
        offer(FN_FREE, cur_base + NUM_PAGES * PG, 4);            // wholly past the map
        offer(FN_FREE, '1, 1);
        offer(FN_FREE, cur_base, CNT_W'(NUM_PAGES));
        offer(FN_ALLOC, '1, 2);
        offer(FN_ALLOC, '0, 2);
        offer(FN_ALLOC, '0, 2);
        offer(FN_FREE, cur_base + 2 * PG, 2);
        offer(FN_ALLOC, '0, 3);                                  // skips the short hole
        offer(FN_ALLOC, '0, 2);                                  // fills the hole

        run_phase(1'b0, BASE_RESET, 600);
        run_phase(1'b1, 32'h0000_0000, 400);
        run_phase(1'b1, 32'hFFFF_FFFF, 200);
        run_phase(1'b1, $urandom_range(32'h0000_1000, 32'h7FFF_FFFF), 700);
        drain;
        repeat (100) @(posedge i_clk);

        $display("covered %0d granted and %0d refused allocations, %0d rejected, %0d frees",
                 granted, refused, rejected, frees);
        $display("across %0d base settings (reset, zero, all ones, random), with hold-offs",
                 phases);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
